/* sv/ghi_pkg.sv */
// ----------------------------------------------------------------------------
// ghi_pkg
// Types and fixed constants shared by the gyro heading integrator.
// ----------------------------------------------------------------------------
package ghi_pkg;

    // field widths
    localparam int RATE_SAMPLE_W = 16;
    localparam int OFFSET_W      = 16;
    localparam int PERIOD_W      = 16;
    localparam int TOL_W         = 20;
    localparam int HEADING_W     = 31;
    localparam int RATE_RAD_W    = 21;
    localparam int HEAD_ACC_W    = 32;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

    localparam t_cfg_idx REG_RATE_OFFSET   = 2'd0;
    localparam t_cfg_idx REG_SAMPLE_PERIOD = 2'd1;
    localparam t_cfg_idx REG_STEP_TOL      = 2'd2;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd5000;

    typedef logic signed [RATE_SAMPLE_W-1:0] t_rate_sample;
    typedef logic signed [HEADING_W-1:0]     t_heading;
    typedef logic signed [RATE_RAD_W-1:0]    t_rate_rad;

    // shared multiplier: signed A times unsigned B
    localparam int MUL_A_W = 31;
    localparam int MUL_B_W = 32;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // pi/180 in units of 2^-32
    localparam logic [MUL_B_W-1:0] DEG2RAD_Q32 = 32'd74961321;
    // pi in units of 2^-32
    localparam logic [33:0] PI_Q32 = 34'd13493037705;

    // rate saturation limits, as magnitudes
    localparam int SAT_W = RATE_RAD_W + 1;
    localparam logic [SAT_W-1:0] SAT_POS = 22'd1048575;
    localparam logic [SAT_W-1:0] SAT_NEG = 22'd1048576;

    // |rate sum| * period fits in this many bits
    localparam int SUM_PROD_W = 37;

    // angle step: microseconds to seconds, and the trapezoid halving
    localparam int DIVISOR_W = 21;
    localparam logic [DIVISOR_W-1:0] HALF_STEP_DIVISOR = 21'd1000000;

    // 2000000 = 2^7 * 15625: shift off the power of two, then divide by 15625
    // through a reciprocal estimate that is at most one low
    localparam int STEP_DIV_SH = 7;
    localparam int ODD_W       = 14;
    localparam logic [ODD_W-1:0] STEP_DIV_ODD = 14'd15625;
    localparam int EST_PRE_SH  = 13;
    localparam int RECIP_SH    = 32;
    // floor(2^45 / 15625)
    localparam logic [MUL_B_W-1:0] STEP_RECIP = 32'd2251799813;

endpackage

/* sv/ghi_if.sv */
// ----------------------------------------------------------------------------
// ghi_if
// Valid/ready channels of the gyro heading integrator.
// ----------------------------------------------------------------------------
interface ghi_in_if;
    import ghi_pkg::*;
    logic         valid;
    logic         ready;
    t_rate_sample rate_sample;

    modport source (output valid, output rate_sample, input ready);
    modport sink   (input valid, input rate_sample, output ready);
endinterface

interface ghi_out_if;
    import ghi_pkg::*;
    logic      valid;
    logic      ready;
    t_heading  heading;
    t_rate_rad rate_rad;
    logic      step_applied;

    modport source (output valid, output heading, output rate_rad, output step_applied,
                    input ready);
    modport sink   (input valid, input heading, input rate_rad, input step_applied,
                    output ready);
endinterface

interface ghi_cfg_if;
    import ghi_pkg::*;
    logic      valid;
    logic      ready;
    t_cfg_idx  index;
    t_cfg_data data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/ghi_mul.sv */
// ----------------------------------------------------------------------------
// ghi_mul
// Shared multiplier: signed operand times unsigned operand, registered.
// ----------------------------------------------------------------------------
module ghi_mul #(
    parameter int AW = 22,
    parameter int BW = 27
) (
    input  logic                    i_clk,
    input  logic signed [AW-1:0]    i_a,
    input  logic        [BW-1:0]    i_b,
    output logic signed [AW+BW-1:0] o_p
);
    logic signed [AW+BW:0]   full;
    logic signed [AW+BW-1:0] r_p;

    assign full = i_a * $signed({1'b0, i_b});

    always_ff @(posedge i_clk) begin
        r_p <= full[AW+BW-1:0];
    end

    assign o_p = r_p;
endmodule

/* sv/ghi_div.sv */
// ----------------------------------------------------------------------------
// ghi_div
// Quotient fix-up for the divide by the step divisor: the reciprocal
// estimate is never high and at most one low, so one compare and subtract
// of the remainder settles it.
// ----------------------------------------------------------------------------
module ghi_div #(
    parameter int DW = 49,
    parameter int QW = 29
) (
    input  logic [DW-1:0]                     i_dividend,
    input  logic [QW-1:0]                     i_q_est,
    input  logic [DW-ghi_pkg::STEP_DIV_SH-1:0] i_back,
    output logic [QW-1:0]                     o_quotient
);
    import ghi_pkg::*;

    localparam int EW = DW - STEP_DIV_SH;

    logic [EW-1:0] e_val;
    logic [EW-1:0] rem;
    logic          ge;

    // i_back is the estimate times 15625, never above e_val
    assign e_val      = i_dividend[DW-1:STEP_DIV_SH];
    assign rem        = e_val - i_back;
    assign ge         = rem >= EW'(STEP_DIV_ODD);
    assign o_quotient = i_q_est + QW'(ge);
endmodule

/* sv/gyro_heading_integrator_top.sv */
// ----------------------------------------------------------------------------
// gyro_heading_integrator_top
// Integrates z gyro rate samples into a wrapped heading, trapezoidal rule.
// ----------------------------------------------------------------------------
// Usage:
//   i_in   : one raw rate sample per transfer (2^-RATE_FRAC_BITS deg/s).
//   o_out  : one result per sample: heading (2^-ANGLE_FRAC_BITS rad),
//            corrected rate (2^-16 rad/s, saturated) and the applied flag.
//   i_cfg  : register writes (0 rate_offset, 1 sample_period_us,
//            2 step_tolerance); always ready, write only while idle.
// Timing:
//   A sample steps through the states MUL1 to WRAP to a valid result. One
//   registered multiplier serves four products in turn: the deg to rad
//   scale, rate sum times period, a reciprocal estimate of the divide by
//   2000000 and its back-multiply; one compare and subtract fixes the
//   estimate. i_in.ready is high only while the sequencer is idle, so a new
//   sample is taken only once the last one has left its last step.
//   The result sits in an output register; the next sample is accepted while
//   it waits, and that sample holds in its last step until o_out is free.
// Reset: heading, previous rate and the sequencer clear; registers return to
//   offset 0, period 5000 us, tolerance 0.
// ----------------------------------------------------------------------------
module gyro_heading_integrator_top #(
    parameter int ANGLE_FRAC_BITS = 28,
    parameter int RATE_FRAC_BITS  = 7
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ghi_in_if.sink    i_in,
    ghi_out_if.source o_out,
    ghi_cfg_if.sink   i_cfg
);
    import ghi_pkg::*;

    localparam int RATE_SH = 16 + RATE_FRAC_BITS;
    localparam int STEP_SH = ANGLE_FRAC_BITS - 16;
    localparam int DVD_W   = ANGLE_FRAC_BITS + 21;
    localparam int QUO_W   = ANGLE_FRAC_BITS + 1;
    localparam int EW      = DVD_W - STEP_DIV_SH;
    localparam int EST_SH  = STEP_DIV_SH + EST_PRE_SH;
    localparam int PI_SH   = 32 - ANGLE_FRAC_BITS;
    localparam int HSUM_W  = 35;
    localparam int CMP_W   = 32;

    localparam logic [33:0] PI_UNITS =
        34'((64'(PI_Q32) + (64'd1 << (PI_SH - 1))) >> PI_SH);
    localparam logic signed [HSUM_W-1:0]     PI_S     = HSUM_W'(PI_UNITS);
    localparam logic signed [HSUM_W-1:0]     TWO_PI_S = HSUM_W'({PI_UNITS, 1'b0});
    localparam logic signed [HEAD_ACC_W-1:0] PI_ACC   = HEAD_ACC_W'(PI_UNITS);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL1  = 4'd1;
    localparam logic [3:0] S_ABS1  = 4'd2;
    localparam logic [3:0] S_RATE  = 4'd3;
    localparam logic [3:0] S_SUM   = 4'd4;
    localparam logic [3:0] S_MUL2  = 4'd5;
    localparam logic [3:0] S_ABS2  = 4'd6;
    localparam logic [3:0] S_EST   = 4'd7;
    localparam logic [3:0] S_MUL3  = 4'd8;
    localparam logic [3:0] S_QBACK = 4'd9;
    localparam logic [3:0] S_MUL4  = 4'd10;
    localparam logic [3:0] S_CORR  = 4'd11;
    localparam logic [3:0] S_ACC   = 4'd12;
    localparam logic [3:0] S_WRAP  = 4'd13;

    // configuration
    logic signed [OFFSET_W-1:0] r_offset;
    logic        [PERIOD_W-1:0] r_period;
    logic        [TOL_W-1:0]    r_tol;

    // state
    logic [3:0]                    r_state;
    t_rate_rad                     r_prev;
    logic signed [HEAD_ACC_W-1:0]  r_acc;

    // datapath
    logic signed [MUL_A_W-1:0] r_a;
    logic        [MUL_B_W-1:0] r_b;
    logic signed [MUL_P_W-1:0] prod;
    logic        [MUL_P_W-1:0] r_mag;
    logic                      r_neg;
    t_rate_rad                 r_rate;
    logic        [DVD_W-1:0]   r_dvd;
    logic        [QUO_W-1:0]   r_q;
    logic        [QUO_W-1:0]   r_quo;
    logic signed [HSUM_W-1:0]  r_hsum;
    logic                      r_applied;

    // output register
    logic      r_ov;
    t_heading  r_oh;
    t_rate_rad r_orate;
    logic      r_oapp;

    logic                     in_xfer;
    logic                     out_free;
    logic [MUL_P_W:0]         rnd_sum;
    logic [MUL_P_W:0]         rnd_q;
    logic [SAT_W-1:0]         rate_lim;
    t_rate_rad                rate_val;
    logic [DVD_W-1:0]         dividend;
    logic [QUO_W-1:0]         q_est;
    logic [QUO_W-1:0]         quotient;
    logic                     applied;
    logic signed [HSUM_W-1:0] step_mag_s;
    logic signed [HSUM_W-1:0] step_s;
    logic signed [HSUM_W-1:0] hsum;
    logic signed [HSUM_W-1:0] wrapped;

    ghi_mul #(.AW(MUL_A_W), .BW(MUL_B_W)) u_mul (
        .i_clk (i_clk),
        .i_a   (r_a),
        .i_b   (r_b),
        .o_p   (prod)
    );

    ghi_div #(.DW(DVD_W), .QW(QUO_W)) u_div (
        .i_dividend (r_dvd),
        .i_q_est    (r_q),
        .i_back     (prod[EW-1:0]),
        .o_quotient (quotient)
    );

    assign i_in.ready  = (r_state == S_IDLE);
    assign in_xfer     = i_in.valid && i_in.ready;
    assign out_free    = !r_ov || o_out.ready;
    assign i_cfg.ready = 1'b1;

    // rate: round half away from zero, then saturate
    assign rnd_sum = {1'b0, r_mag} + ((MUL_P_W + 1)'(1) << (RATE_SH - 1));
    assign rnd_q   = rnd_sum >> RATE_SH;

    always_comb begin
        if (r_neg) begin
            rate_lim = (rnd_q > (MUL_P_W + 1)'(SAT_NEG)) ? SAT_NEG : rnd_q[SAT_W-1:0];
            rate_val = RATE_RAD_W'(-rate_lim);
        end else begin
            rate_lim = (rnd_q > (MUL_P_W + 1)'(SAT_POS)) ? SAT_POS : rnd_q[SAT_W-1:0];
            rate_val = RATE_RAD_W'(rate_lim);
        end
    end

    // step dividend: |sum * period| scaled to angle units, plus half divisor
    assign dividend = (DVD_W'(r_mag[SUM_PROD_W-1:0]) << STEP_SH) + DVD_W'(HALF_STEP_DIVISOR);

    // top bits of (dividend >> 20) * floor(2^45 / 15625) give the estimate
    assign q_est = prod[RECIP_SH +: QUO_W];

    assign applied    = CMP_W'(r_quo) >= CMP_W'(r_tol);
    assign step_mag_s = $signed(HSUM_W'(r_quo));
    assign step_s     = r_neg ? -step_mag_s : step_mag_s;
    assign hsum       = applied ? (HSUM_W'(r_acc) + step_s) : HSUM_W'(r_acc);

    always_comb begin
        priority if (r_hsum > PI_S) begin
            wrapped = r_hsum - TWO_PI_S;
        end else if (r_hsum < -PI_S) begin
            wrapped = r_hsum + TWO_PI_S;
        end else begin
            wrapped = r_hsum;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
            r_period <= PERIOD_RESET;
            r_tol    <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                REG_RATE_OFFSET:   r_offset <= OFFSET_W'(i_cfg.data);
                REG_SAMPLE_PERIOD: r_period <= PERIOD_W'(i_cfg.data);
                REG_STEP_TOL:      r_tol    <= i_cfg.data[TOL_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_prev  <= '0;
            r_acc   <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (r_state == S_WRAP && out_free) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE:  if (in_xfer) r_state <= S_MUL1;
                S_MUL1:  r_state <= S_ABS1;
                S_ABS1:  r_state <= S_RATE;
                S_RATE:  r_state <= S_SUM;
                S_SUM:   r_state <= S_MUL2;
                S_MUL2:  r_state <= S_ABS2;
                S_ABS2:  r_state <= S_EST;
                S_EST:   r_state <= S_MUL3;
                S_MUL3:  r_state <= S_QBACK;
                S_QBACK: r_state <= S_MUL4;
                S_MUL4:  r_state <= S_CORR;
                S_CORR:  r_state <= S_ACC;
                S_ACC:   r_state <= S_WRAP;
                S_WRAP: begin
                    if (out_free) begin
                        r_acc   <= HEAD_ACC_W'(wrapped);
                        r_prev  <= r_rate;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_a <= MUL_A_W'(i_in.rate_sample) - MUL_A_W'(r_offset);
            r_b <= DEG2RAD_Q32;
        end
        if (r_state == S_ABS1 || r_state == S_ABS2) begin
            r_neg <= prod[MUL_P_W-1];
            r_mag <= prod[MUL_P_W-1] ? MUL_P_W'(-prod) : MUL_P_W'(prod);
        end
        if (r_state == S_RATE) begin
            r_rate <= rate_val;
        end
        if (r_state == S_SUM) begin
            r_a <= MUL_A_W'(r_prev) + MUL_A_W'(r_rate);
            r_b <= MUL_B_W'(r_period);
        end
        if (r_state == S_EST) begin
            r_dvd <= dividend;
            r_a   <= MUL_A_W'(dividend[DVD_W-1:EST_SH]);
            r_b   <= STEP_RECIP;
        end
        if (r_state == S_QBACK) begin
            r_q <= q_est;
            r_a <= MUL_A_W'(q_est);
            r_b <= MUL_B_W'(STEP_DIV_ODD);
        end
        if (r_state == S_CORR) begin
            r_quo <= quotient;
        end
        if (r_state == S_ACC) begin
            r_hsum    <= hsum;
            r_applied <= applied;
        end
        if (r_state == S_WRAP && out_free) begin
            r_oh    <= wrapped[HEADING_W-1:0];
            r_orate <= r_rate;
            r_oapp  <= r_applied;
        end
    end

    assign o_out.valid        = r_ov;
    assign o_out.heading      = r_oh;
    assign o_out.rate_rad     = r_orate;
    assign o_out.step_applied = r_oapp;

    // heading stays inside the wrap band
    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_acc <= PI_ACC) && (r_acc >= -PI_ACC))
        else $error("heading accumulator outside [-pi, pi]");

    // the reciprocal estimate never overshoots the true quotient
    a_est_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CORR) |-> (prod[EW-1:0] <= r_dvd[DVD_W-1:STEP_DIV_SH]))
        else $error("step quotient estimate too high");

    // a pending result carries the rate that became the previous rate
    a_prev_matches_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.rate_rad == r_prev))
        else $error("pending rate differs from stored previous rate");

    // once a result is pending, it and the heading accumulator stay until the transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=> (o_out.valid && $stable(r_acc)))
        else $error("pending result dropped or heading changed");

endmodule

/* sim/gyro_heading_integrator_top_tb.sv */
// ----------------------------------------------------------------------------
// gyro_heading_integrator_top_tb
// Drives rate samples and register writes into the heading integrator and
// compares every result against a fixed-point prediction of the heading,
// the corrected rate and the applied flag, under several idle patterns.
// ----------------------------------------------------------------------------
module gyro_heading_integrator_top_tb;
    import ghi_pkg::*;

    localparam int       ANGLE_FRAC      = 28;
    localparam int       RATE_FRAC       = 7;
    localparam t_cfg_idx REG_NONE        = 2'd3;
    localparam longint   CYCLE_LIMIT     = 2000000;
    localparam int       DRAIN_CYCLES    = 80;
    localparam int       PHASES          = 16;
    localparam int       ITEMS_PER_PHASE = 110;

    localparam longint DEG_TO_RAD_Q32 = 74961321;
    localparam longint HALF_TURN_Q32  = 64'sd13493037705;
    localparam longint RATE_CEIL      = 1048575;
    localparam longint RATE_FLOOR     = -1048576;
    localparam longint USEC_TRAPEZOID = 2000000;

    localparam t_rate_sample SAMPLE_MAX = 16'sh7fff;
    localparam t_rate_sample SAMPLE_MIN = 16'sh8000;

    typedef struct {
        t_heading  heading;
        t_rate_rad rate_rad;
        logic      step_applied;
    } t_heading_result;

    class heading_scoreboard;
        int                 errors;
        t_heading_result    pending[$];
        logic signed [15:0] rate_offset;
        logic [15:0]        period_us;
        logic [19:0]        step_tol;
        longint             prev_rate;
        longint             heading_acc;

        function new();
            errors      = 0;
            rate_offset = '0;
            period_us   = PERIOD_RESET;
            step_tol    = '0;
            prev_rate   = 0;
            heading_acc = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, t_cfg_data data);
            case (idx)
                REG_RATE_OFFSET:   rate_offset = data[15:0];
                REG_SAMPLE_PERIOD: period_us   = data[15:0];
                REG_STEP_TOL:      step_tol    = data;
                default: ;
            endcase
        endfunction

        // x / d, rounded half away from zero
        function longint div_round(longint x, longint d);
            longint m;
            m = (x < 0) ? -x : x;
            m = (m + d / 2) / d;
            return (x < 0) ? -m : m;
        endfunction

        function void note_sample(t_rate_sample sample);
            longint          corrected;
            longint          rate;
            longint          step;
            longint          half_turn;
            t_heading_result res;
            corrected = longint'(sample) - longint'(rate_offset);
            rate = div_round(corrected * DEG_TO_RAD_Q32, 64'sd1 <<< (16 + RATE_FRAC));
            if (rate > RATE_CEIL) rate = RATE_CEIL;
            if (rate < RATE_FLOOR) rate = RATE_FLOOR;
            // trapezoid: (prev + cur) / 2 * period, period in us
            step = div_round((prev_rate + rate) * longint'(period_us)
                             * (64'sd1 <<< (ANGLE_FRAC - 16)), USEC_TRAPEZOID);
            res.step_applied = (((step < 0) ? -step : step) >= longint'(step_tol));
            if (res.step_applied) begin
                half_turn = (HALF_TURN_Q32 + (64'sd1 <<< (31 - ANGLE_FRAC)))
                            >>> (32 - ANGLE_FRAC);
                heading_acc = heading_acc + step;
                if (heading_acc > half_turn)
                    heading_acc = heading_acc - 2 * half_turn;
                else if (heading_acc < -half_turn)
                    heading_acc = heading_acc + 2 * half_turn;
            end
            prev_rate    = rate;
            res.heading  = heading_acc[HEADING_W-1:0];
            res.rate_rad = rate[RATE_RAD_W-1:0];
            pending.push_back(res);
        endfunction

        function void check_result(t_heading heading, t_rate_rad rate_rad, logic applied);
            t_heading_result want;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: unexpected result heading %0d rate %0d applied %0b",
                         $time, heading, rate_rad, applied);
                return;
            end
            want = pending.pop_front();
            if (heading !== want.heading) begin
                errors++;
                $display("%0t: heading expected %0d, got %0d", $time, want.heading, heading);
            end
            if (rate_rad !== want.rate_rad) begin
                errors++;
                $display("%0t: rate_rad expected %0d, got %0d", $time, want.rate_rad, rate_rad);
            end
            if (applied !== want.step_applied) begin
                errors++;
                $display("%0t: step_applied expected %0b, got %0b",
                         $time, want.step_applied, applied);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    ghi_in_if  in_ch();
    ghi_out_if out_ch();
    ghi_cfg_if cfg_ch();

    gyro_heading_integrator_top #(
        .ANGLE_FRAC_BITS(ANGLE_FRAC),
        .RATE_FRAC_BITS (RATE_FRAC)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch),
        .i_cfg  (cfg_ch)
    );

    heading_scoreboard heading_sb = new();

    int     tx_idle_pct  = 0;
    int     rx_stall_pct = 0;
    int     rx_hold      = 0;
    longint cycles       = 0;

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // mostly short gaps, now and then one long enough to span a whole sample
    function automatic int stall_length();
        return ($urandom_range(9) == 0) ? $urandom_range(80, 1) : $urandom_range(4, 1);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready)
                heading_sb.write_reg(cfg_ch.index, cfg_ch.data);
            if (in_ch.valid && in_ch.ready)
                heading_sb.note_sample(in_ch.rate_sample);
            if (out_ch.valid && out_ch.ready)
                heading_sb.check_result(out_ch.heading, out_ch.rate_rad, out_ch.step_applied);
        end
    end

    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            rx_hold      <= rx_hold - 1;
            out_ch.ready <= 1'b0;
        end else if ($urandom_range(99) < rx_stall_pct) begin
            rx_hold      <= stall_length() - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // entered and left at a falling edge; valid stays high for the next sample
    task automatic send_sample(input t_rate_sample sample);
        if ($urandom_range(99) < tx_idle_pct) begin
            in_ch.valid = 1'b0;
            repeat (stall_length()) @(negedge i_clk);
        end
        in_ch.valid       = 1'b1;
        in_ch.rate_sample = sample;
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
        @(negedge i_clk);
    endtask

    task automatic program_reg(input t_cfg_idx idx, input t_cfg_data data);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = data;
        do @(posedge i_clk); while (!(cfg_ch.valid && cfg_ch.ready));
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic wait_drained();
        in_ch.valid = 1'b0;
        while (heading_sb.pending.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        t_rate_sample sample;
        logic         drift_up;
        i_rst_n           = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.rate_sample = '0;
        out_ch.ready      = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = REG_RATE_OFFSET;
        cfg_ch.data       = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset registers, sample extremes
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(16'sd0);
        send_sample(-16'sd1);
        send_sample(16'sd1);

        // full-scale positive rate, longest period: heading wraps past +pi
        wait_drained();
        program_reg(REG_RATE_OFFSET, 20'hf8000);
        program_reg(REG_SAMPLE_PERIOD, 20'hfffff);
        program_reg(REG_STEP_TOL, 20'd0);
        repeat (7) send_sample(SAMPLE_MAX);

        // full-scale negative rate: wraps past -pi
        wait_drained();
        program_reg(REG_RATE_OFFSET, 20'h07fff);
        program_reg(REG_STEP_TOL, 20'd1000);
        repeat (8) send_sample(SAMPLE_MIN);

        // zero period with zero tolerance still applies the zero step
        wait_drained();
        program_reg(REG_SAMPLE_PERIOD, 20'd0);
        program_reg(REG_STEP_TOL, 20'd0);
        repeat (2) send_sample(t_rate_sample'($urandom));

        // out-of-range index must not disturb anything
        wait_drained();
        program_reg(REG_STEP_TOL, 20'hfffff);
        program_reg(REG_NONE, t_cfg_data'($urandom));
        repeat (2) send_sample(t_rate_sample'($urandom));

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            case (ph % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 50; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 50; end
                default: begin tx_idle_pct = 35; rx_stall_pct = 35; end
            endcase
            case ($urandom_range(3))
                0: program_reg(REG_RATE_OFFSET, t_cfg_data'($urandom));
                1: program_reg(REG_RATE_OFFSET, 20'h08000);
                2: program_reg(REG_RATE_OFFSET, 20'h07fff);
                default: program_reg(REG_RATE_OFFSET, 20'h00000);
            endcase
            case ($urandom_range(5))
                0: program_reg(REG_SAMPLE_PERIOD, 20'd1);
                1: program_reg(REG_SAMPLE_PERIOD, 20'h0ffff);
                2: program_reg(REG_SAMPLE_PERIOD, 20'd0);
                3: program_reg(REG_SAMPLE_PERIOD, 20'd5000);
                default: program_reg(REG_SAMPLE_PERIOD, t_cfg_data'($urandom));
            endcase
            case ($urandom_range(4))
                0: program_reg(REG_STEP_TOL, 20'd0);
                1: program_reg(REG_STEP_TOL, 20'hfffff);
                2: program_reg(REG_STEP_TOL, t_cfg_data'($urandom_range(4095)));
                default: program_reg(REG_STEP_TOL, t_cfg_data'($urandom));
            endcase
            if ($urandom_range(3) == 0)
                program_reg(REG_NONE, t_cfg_data'($urandom));

            // a steady one-sign drift per phase drives the heading around the wrap
            drift_up = 1'($urandom_range(1));
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                case ($urandom_range(9))
                    0: sample = SAMPLE_MAX;
                    1: sample = SAMPLE_MIN;
                    2: sample = heading_sb.rate_offset
                                + t_rate_sample'($urandom_range(6) - 3);
                    3, 4, 5: begin
                        if (drift_up)
                            sample = t_rate_sample'($urandom_range(32767, 4096));
                        else
                            sample = t_rate_sample'(32'd0 - $urandom_range(32768, 4096));
                    end
                    default: sample = t_rate_sample'($urandom);
                endcase
                send_sample(sample);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (heading_sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
